// ----- rtl/ookpe_pkg.sv -----
// Shared types, constants and helpers for the OOK remote pulse encoder.
// No dependencies; used by all rtl modules.
package ookpe_pkg;

  // Frame layout and timing
  localparam int REPEATS         = 5;
  localparam int PAUSE_LOW_TICKS = 10000;
  localparam int TX_CODE_MAX     = 32;
  localparam int CH_CODE_MAX     = 8;

  localparam int TICK_W = 16;
  localparam int REP_W  = 3;
  localparam int POS_W  = 6;
  localparam int PART_W = 3;

  // Frame parts, in send order
  localparam logic [PART_W-1:0] PART_SYNC  = 3'd0;
  localparam logic [PART_W-1:0] PART_TX    = 3'd1;
  localparam logic [PART_W-1:0] PART_GROUP = 3'd2;
  localparam logic [PART_W-1:0] PART_ONOFF = 3'd3;
  localparam logic [PART_W-1:0] PART_CH    = 3'd4;
  localparam logic [PART_W-1:0] PART_UNIT  = 3'd5;
  localparam logic [PART_W-1:0] PART_PAUSE = 3'd6;

  // Configuration register indexes
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] REG_TX_CODE   = 4'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TX_LEN    = 4'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_CH_CODE   = 4'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_CH_LEN    = 4'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_HIGH      = 4'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_ONE_LOW   = 4'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_ZERO_LOW  = 4'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_SYNC_LOW  = 4'd7;

  localparam logic [TICK_W-1:0] HIGH_RST     = 16'd250;
  localparam logic [TICK_W-1:0] ONE_LOW_RST  = 16'd250;
  localparam logic [TICK_W-1:0] ZERO_LOW_RST = 16'd1250;
  localparam logic [TICK_W-1:0] SYNC_LOW_RST = 16'd2500;

  // Command bit codes
  localparam logic [1:0] GROUP_ALL  = 2'b01;
  localparam logic [1:0] GROUP_UNIT = 2'b10;
  localparam logic [1:0] CODE_ON    = 2'b01;
  localparam logic [1:0] CODE_OFF   = 2'b10;
  localparam logic [1:0] DEV_GROUP  = 2'd3;

  typedef struct packed {
    logic       action;
    logic [1:0] device;
    logic       turn_on;
  } in_item_t;

  typedef struct packed {
    logic tx_level;
    logic busy_res;
    logic command_ignored;
  } out_item_t;

  typedef struct packed {
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

  typedef struct packed {
    logic [31:0]       tx_code;
    logic [5:0]        tx_len;
    logic [7:0]        ch_code;
    logic [3:0]        ch_len;
    logic [TICK_W-1:0] high_ticks;
    logic [TICK_W-1:0] one_low_ticks;
    logic [TICK_W-1:0] zero_low_ticks;
    logic [TICK_W-1:0] sync_low_ticks;
  } cfg_t;

  typedef struct packed {
    logic              active;
    logic [PART_W-1:0] part;
    logic [POS_W-1:0]  bit_pos;
    logic [REP_W-1:0]  rep_count;
  } seq_status_t;

  // Unit code for a single device; the group uses 1001.
  function automatic logic [3:0] unit_code(input logic [1:0] device);
    logic [3:0] code;
    case (device)
      2'd0:    code = 4'b1010;
      2'd1:    code = 4'b1001;
      2'd2:    code = 4'b0110;
      default: code = 4'b1001;
    endcase
    return code;
  endfunction

endpackage

// ----- rtl/ookpe_vr_if.sv -----
// Valid/ready channel carrying one item of a given payload type.
// Payload types come from ookpe_pkg.
interface ookpe_vr_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/ookpe_cfg_regs.sv -----
// Configuration register file for the pulse encoder.
// Depends on ookpe_pkg and ookpe_vr_if.
module ookpe_cfg_regs (
  input  logic              clk,
  input  logic              rst,
  ookpe_vr_if.sink          cfg,
  output ookpe_pkg::cfg_t   regs
);

  logic wr;

  assign cfg.ready = 1'b1;
  assign wr = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.tx_code        <= '0;
      regs.tx_len         <= '0;
      regs.ch_code        <= '0;
      regs.ch_len         <= '0;
      regs.high_ticks     <= ookpe_pkg::HIGH_RST;
      regs.one_low_ticks  <= ookpe_pkg::ONE_LOW_RST;
      regs.zero_low_ticks <= ookpe_pkg::ZERO_LOW_RST;
      regs.sync_low_ticks <= ookpe_pkg::SYNC_LOW_RST;
    end else if (wr) begin
      case (cfg.data.addr)
        ookpe_pkg::REG_TX_CODE:  regs.tx_code        <= cfg.data.wdata;
        ookpe_pkg::REG_TX_LEN:   regs.tx_len         <= cfg.data.wdata[5:0];
        ookpe_pkg::REG_CH_CODE:  regs.ch_code        <= cfg.data.wdata[7:0];
        ookpe_pkg::REG_CH_LEN:   regs.ch_len         <= cfg.data.wdata[3:0];
        ookpe_pkg::REG_HIGH:     regs.high_ticks     <= cfg.data.wdata[15:0];
        ookpe_pkg::REG_ONE_LOW:  regs.one_low_ticks  <= cfg.data.wdata[15:0];
        ookpe_pkg::REG_ZERO_LOW: regs.zero_low_ticks <= cfg.data.wdata[15:0];
        ookpe_pkg::REG_SYNC_LOW: regs.sync_low_ticks <= cfg.data.wdata[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/ookpe_seq.sv -----
// Frame sequencer: symbol/bit/tick state and the per-item next-state logic.
// Depends on ookpe_pkg.
module ookpe_seq #(
  parameter int REPEATS         = ookpe_pkg::REPEATS,
  parameter int PAUSE_LOW_TICKS = ookpe_pkg::PAUSE_LOW_TICKS,
  parameter int TX_CODE_MAX     = ookpe_pkg::TX_CODE_MAX,
  parameter int CH_CODE_MAX     = ookpe_pkg::CH_CODE_MAX
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    step,
  input  ookpe_pkg::in_item_t     item,
  input  ookpe_pkg::cfg_t         regs,
  output ookpe_pkg::out_item_t    result,
  output ookpe_pkg::seq_status_t  status
);

  logic                               active, active_next;
  logic [ookpe_pkg::PART_W-1:0]       part, part_next;
  logic [ookpe_pkg::POS_W-1:0]        bit_pos, bit_pos_next;
  logic                               low_half, low_half_next;
  logic [ookpe_pkg::TICK_W-1:0]       tick_count, tick_count_next;
  logic [ookpe_pkg::REP_W-1:0]        rep_count, rep_count_next;
  logic [7:0]                         cmd_bits, cmd_bits_next;

  logic [5:0]                         tx_len;
  logic [3:0]                         ch_len;
  logic [5:0]                         cur_len;
  logic [4:0]                         idx;
  logic                               cur_bit;
  logic [ookpe_pkg::TICK_W-1:0]       dur;
  logic [ookpe_pkg::TICK_W:0]         cnt;
  logic [ookpe_pkg::POS_W:0]          pos_inc;
  logic [ookpe_pkg::REP_W:0]          rep_inc;
  logic [ookpe_pkg::PART_W-1:0]       part_adv;

  always_comb begin
    tx_len = (regs.tx_len > 6'(TX_CODE_MAX)) ? 6'(TX_CODE_MAX) : regs.tx_len;
    ch_len = (regs.ch_len > 4'(CH_CODE_MAX)) ? 4'(CH_CODE_MAX) : regs.ch_len;

    case (part)
      ookpe_pkg::PART_TX:    cur_len = tx_len;
      ookpe_pkg::PART_CH:    cur_len = {2'b00, ch_len};
      ookpe_pkg::PART_GROUP: cur_len = 6'd2;
      ookpe_pkg::PART_ONOFF: cur_len = 6'd2;
      ookpe_pkg::PART_UNIT:  cur_len = 6'd4;
      default:               cur_len = 6'd1;
    endcase

    // bits go out most significant first
    idx = 5'(cur_len - 6'd1 - bit_pos);
    case (part)
      ookpe_pkg::PART_TX:    cur_bit = regs.tx_code[idx];
      // a length cut below the position points past the 8 code bits: reads 0
      ookpe_pkg::PART_CH:    cur_bit = (idx < 5'd8) ? regs.ch_code[idx[2:0]] : 1'b0;
      ookpe_pkg::PART_GROUP: cur_bit = cmd_bits[3'd6 + {2'b00, idx[0]}];
      ookpe_pkg::PART_ONOFF: cur_bit = cmd_bits[3'd4 + {2'b00, idx[0]}];
      ookpe_pkg::PART_UNIT:  cur_bit = cmd_bits[{1'b0, idx[1:0]}];
      default:               cur_bit = 1'b0;
    endcase

    if (!low_half) begin
      dur = regs.high_ticks;
    end else if (part == ookpe_pkg::PART_SYNC) begin
      dur = regs.sync_low_ticks;
    end else if (part >= ookpe_pkg::PART_PAUSE) begin
      dur = ookpe_pkg::TICK_W'(PAUSE_LOW_TICKS);
    end else begin
      dur = cur_bit ? regs.one_low_ticks : regs.zero_low_ticks;
    end

    cnt     = {1'b0, tick_count} + 1'b1;
    pos_inc = {1'b0, bit_pos} + 1'b1;
    rep_inc = {1'b0, rep_count} + 1'b1;

    // empty code parts are skipped
    part_adv = part + 1'b1;
    if (part_adv == ookpe_pkg::PART_TX && tx_len == '0) begin
      part_adv = ookpe_pkg::PART_GROUP;
    end else if (part_adv == ookpe_pkg::PART_CH && ch_len == '0) begin
      part_adv = ookpe_pkg::PART_UNIT;
    end

    active_next     = active;
    part_next       = part;
    bit_pos_next    = bit_pos;
    low_half_next   = low_half;
    tick_count_next = tick_count;
    rep_count_next  = rep_count;
    cmd_bits_next   = cmd_bits;
    result          = '0;

    if (item.action) begin
      result.busy_res = 1'b1;
      if (active) begin
        result.command_ignored = 1'b1;
      end else begin
        cmd_bits_next = {(item.device == ookpe_pkg::DEV_GROUP) ?
                         ookpe_pkg::GROUP_ALL : ookpe_pkg::GROUP_UNIT,
                         item.turn_on ? ookpe_pkg::CODE_ON : ookpe_pkg::CODE_OFF,
                         ookpe_pkg::unit_code(item.device)};
        active_next     = 1'b1;
        rep_count_next  = '0;
        low_half_next   = 1'b0;
        tick_count_next = '0;
        part_next       = ookpe_pkg::PART_SYNC;
        bit_pos_next    = '0;
      end
    end else if (active) begin
      result.tx_level = !low_half;
      if (cnt >= {1'b0, dur}) begin
        tick_count_next = '0;
        low_half_next   = !low_half;
        if (low_half) begin
          if (pos_inc < {1'b0, cur_len}) begin
            bit_pos_next = pos_inc[ookpe_pkg::POS_W-1:0];
          end else if (part >= ookpe_pkg::PART_PAUSE) begin
            bit_pos_next = '0;
            part_next    = ookpe_pkg::PART_SYNC;
            if (rep_inc >= (ookpe_pkg::REP_W+1)'(REPEATS)) begin
              active_next    = 1'b0;
              rep_count_next = '0;
            end else begin
              rep_count_next = rep_inc[ookpe_pkg::REP_W-1:0];
            end
          end else begin
            part_next    = part_adv;
            bit_pos_next = '0;
          end
        end
      end else begin
        tick_count_next = cnt[ookpe_pkg::TICK_W-1:0];
      end
      result.busy_res = active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active     <= 1'b0;
      part       <= ookpe_pkg::PART_SYNC;
      bit_pos    <= '0;
      low_half   <= 1'b0;
      tick_count <= '0;
      rep_count  <= '0;
      cmd_bits   <= '0;
    end else if (step) begin
      active     <= active_next;
      part       <= part_next;
      bit_pos    <= bit_pos_next;
      low_half   <= low_half_next;
      tick_count <= tick_count_next;
      rep_count  <= rep_count_next;
      cmd_bits   <= cmd_bits_next;
    end
  end

  assign status.active    = active;
  assign status.part      = part;
  assign status.bit_pos   = bit_pos;
  assign status.rep_count = rep_count;

endmodule

// ----- rtl/ook_remote_packet_pulse_encoder.sv -----
// OOK remote pulse-distance encoder: block top with input and result registers.
// Depends on ookpe_pkg, ookpe_vr_if, ookpe_cfg_regs and ookpe_seq.
//
// Usage:
//  cmd: one item per tick (action 0) or send command (action 1, device, turn_on).
//  rsp: one result item per cmd item, in order: tx_level, busy_res, command_ignored.
//  cfg: register writes (addr = register index, wdata); always ready. Write only
//       while no items are in flight. Unknown indexes are dropped.
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while rsp is taken; the sequencer state steps
// once per item, all in one pass of next-state logic.
// Stall: when rsp is not taken, the result register holds; one more item is
// taken into the input register, then cmd.ready drops until rsp moves.
// Reset (rst, synchronous): both registers empty, line idle, registers back to
// defaults (high 250, one 250, zero 1250, sync 2500 ticks, code lengths 0).
// A send command while a transmission runs is dropped and flagged.
module ook_remote_packet_pulse_encoder #(
  parameter int REPEATS         = ookpe_pkg::REPEATS,
  parameter int PAUSE_LOW_TICKS = ookpe_pkg::PAUSE_LOW_TICKS,
  parameter int TX_CODE_MAX     = ookpe_pkg::TX_CODE_MAX,
  parameter int CH_CODE_MAX     = ookpe_pkg::CH_CODE_MAX
) (
  input  logic        clk,
  input  logic        rst,
  ookpe_vr_if.sink    cfg,
  ookpe_vr_if.sink    cmd,
  ookpe_vr_if.source  rsp
);

  ookpe_pkg::cfg_t        regs;
  ookpe_pkg::seq_status_t status;
  ookpe_pkg::in_item_t    in_item;
  ookpe_pkg::out_item_t   seq_result;
  ookpe_pkg::out_item_t   res_item;
  logic                   in_valid;
  logic                   res_valid;
  logic                   res_load;
  logic                   step;

  ookpe_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  ookpe_seq #(
    .REPEATS         (REPEATS),
    .PAUSE_LOW_TICKS (PAUSE_LOW_TICKS),
    .TX_CODE_MAX     (TX_CODE_MAX),
    .CH_CODE_MAX     (CH_CODE_MAX)
  ) u_seq (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (in_item),
    .regs   (regs),
    .result (seq_result),
    .status (status)
  );

  assign res_load  = !res_valid || rsp.ready;
  assign step      = in_valid && res_load;
  assign cmd.ready = !in_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (cmd.ready) begin
      in_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      in_item <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_item <= seq_result;
    end
  end

  assign rsp.valid = res_valid;
  assign rsp.data  = res_item;

`ifndef SYNTHESIS
  a_rep_bound: assert property (@(posedge clk) disable iff (rst)
    status.rep_count < ookpe_pkg::REP_W'(REPEATS))
    else $error("repeat count out of range");

  a_idle_sync: assert property (@(posedge clk) disable iff (rst)
    !status.active |-> (status.part == ookpe_pkg::PART_SYNC && status.bit_pos == '0))
    else $error("idle sequencer not parked at sync");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (in_valid && res_valid && !rsp.ready) |-> !cmd.ready)
    else $error("input taken while both stages are full");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (in_valid && res_load) |=> res_valid)
    else $error("stepped item did not reach the result register");
`endif

endmodule

// ----- tb/tb_ook_remote_packet_pulse_encoder.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the OOK remote pulse encoder: drives ticks, commands and
// register writes, predicts every result item. Needs ookpe_pkg, ookpe_vr_if, the rtl.
module tb_ook_remote_packet_pulse_encoder;

  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  localparam int unsigned MAX_REPORTS   = 100;
  localparam int unsigned RANDOM_ROUNDS = 3;
  localparam int unsigned ROUND_ITEMS   = 400;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned DEFAULT_TICKS = 270;
  localparam int unsigned SHORT_TICKS   = 20;
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SEND = 1'b1;
  localparam logic [ookpe_pkg::CFG_ADDR_W-1:0] REG_SPARE = ookpe_pkg::REG_SYNC_LOW + 4'd1;
  localparam logic [ookpe_pkg::CFG_ADDR_W-1:0] REG_TOP   = '1;
  // unit code per device, device 3 (group) first
  localparam logic [3:0][3:0] UNIT_BITS = {4'b1001, 4'b0110, 4'b1001, 4'b1010};

  logic clk = 1'b0;
  logic rst = 1'b1;

  ookpe_vr_if #(.item_t(ookpe_pkg::cfg_wr_t))   cfg_ch ();
  ookpe_vr_if #(.item_t(ookpe_pkg::in_item_t))  cmd_ch ();
  ookpe_vr_if #(.item_t(ookpe_pkg::out_item_t)) rsp_ch ();

  ook_remote_packet_pulse_encoder u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .cmd (cmd_ch),
    .rsp (rsp_ch)
  );

  always #2 clk = ~clk;

  // encoder shadow state
  ookpe_pkg::cfg_t                enc_cfg;
  logic                           enc_active;
  logic [ookpe_pkg::PART_W-1:0]   enc_part;
  logic [ookpe_pkg::POS_W-1:0]    enc_pos;
  logic                           enc_low;
  logic [ookpe_pkg::TICK_W-1:0]   enc_ticks;
  logic [ookpe_pkg::REP_W-1:0]    enc_rep;
  logic [7:0]                     enc_cmd;

  ookpe_pkg::out_item_t line_states_due[$];
  ookpe_pkg::out_item_t want;
  int unsigned fail_cnt;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned sym_cnt;
  int unsigned ignored_cnt;
  int unsigned cycle_cnt;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned rx_hold_cycles;

  function automatic int unsigned part_bits(logic [ookpe_pkg::PART_W-1:0] p);
    int unsigned n;
    case (p)
      ookpe_pkg::PART_TX:
        n = (enc_cfg.tx_len > ookpe_pkg::TX_CODE_MAX) ? ookpe_pkg::TX_CODE_MAX
                                                       : enc_cfg.tx_len;
      ookpe_pkg::PART_CH:
        n = (enc_cfg.ch_len > ookpe_pkg::CH_CODE_MAX) ? ookpe_pkg::CH_CODE_MAX
                                                       : enc_cfg.ch_len;
      ookpe_pkg::PART_GROUP: n = 2;
      ookpe_pkg::PART_ONOFF: n = 2;
      ookpe_pkg::PART_UNIT:  n = 4;
      default:               n = 1;
    endcase
    return n;
  endfunction

  function automatic logic symbol_bit();
    int unsigned idx;
    logic b;
    idx = (part_bits(enc_part) - 1 - enc_pos) & 31;
    case (enc_part)
      ookpe_pkg::PART_TX:    b = enc_cfg.tx_code[idx];
      // position past a shortened channel code reads as 0
      ookpe_pkg::PART_CH:    b = (idx < 8) ? enc_cfg.ch_code[idx] : 1'b0;
      ookpe_pkg::PART_GROUP: b = enc_cmd[6 + (idx & 1)];
      ookpe_pkg::PART_ONOFF: b = enc_cmd[4 + (idx & 1)];
      ookpe_pkg::PART_UNIT:  b = enc_cmd[idx & 3];
      default:               b = 1'b0;
    endcase
    return b;
  endfunction

  function automatic int unsigned low_len();
    int unsigned n;
    if (enc_part == ookpe_pkg::PART_SYNC) n = enc_cfg.sync_low_ticks;
    else if (enc_part == ookpe_pkg::PART_PAUSE) n = ookpe_pkg::PAUSE_LOW_TICKS;
    else n = symbol_bit() ? enc_cfg.one_low_ticks : enc_cfg.zero_low_ticks;
    return n;
  endfunction

  // empty parts (zero code length) are skipped
  function automatic void enter_part(int unsigned p);
    while (p < ookpe_pkg::PART_PAUSE && part_bits(3'(p)) == 0) p++;
    enc_part = 3'(p);
    enc_pos  = '0;
  endfunction

  function automatic void next_symbol();
    sym_cnt++;
    enc_pos++;
    if (enc_pos < part_bits(enc_part)) return;
    if (enc_part >= ookpe_pkg::PART_PAUSE) begin
      enc_rep++;
      if (enc_rep >= ookpe_pkg::REPEATS) begin
        enc_active = 1'b0;
        enc_rep    = '0;
        enc_part   = ookpe_pkg::PART_SYNC;
        enc_pos    = '0;
      end else begin
        enter_part(ookpe_pkg::PART_SYNC);
      end
    end else begin
      enter_part(enc_part + 1);
    end
  endfunction

  function automatic ookpe_pkg::out_item_t line_step(ookpe_pkg::in_item_t it);
    ookpe_pkg::out_item_t r;
    int unsigned dur;
    int unsigned cnt;
    r = '0;
    if (it.action == ACT_SEND) begin
      r.busy_res = 1'b1;
      if (enc_active) begin
        r.command_ignored = 1'b1;
        ignored_cnt++;
      end else begin
        enc_cmd = {(it.device == ookpe_pkg::DEV_GROUP) ? ookpe_pkg::GROUP_ALL
                                                       : ookpe_pkg::GROUP_UNIT,
                   it.turn_on ? ookpe_pkg::CODE_ON : ookpe_pkg::CODE_OFF,
                   UNIT_BITS[it.device]};
        enc_active = 1'b1;
        enc_rep    = '0;
        enc_low    = 1'b0;
        enc_ticks  = '0;
        enter_part(ookpe_pkg::PART_SYNC);
      end
    end else if (enc_active) begin
      r.tx_level = ~enc_low;
      dur = enc_low ? low_len() : enc_cfg.high_ticks;
      cnt = enc_ticks + 1;
      // a zero duration still lasts one tick
      if (cnt >= dur) begin
        enc_ticks = '0;
        if (!enc_low) begin
          enc_low = 1'b1;
        end else begin
          enc_low = 1'b0;
          next_symbol();
        end
      end else begin
        enc_ticks = cnt[ookpe_pkg::TICK_W-1:0];
      end
      r.busy_res = enc_active;
    end
    return r;
  endfunction

  function automatic int unsigned gap_len(int unsigned pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 15) == 0) return $urandom_range(12, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic ookpe_pkg::in_item_t any_item(logic act);
    ookpe_pkg::in_item_t t;
    t.action  = act;
    t.device  = 2'($urandom_range(0, 3));
    t.turn_on = 1'($urandom_range(0, 1));
    return t;
  endfunction

  function automatic ookpe_pkg::in_item_t cmd_of(logic [1:0] dev, logic on);
    ookpe_pkg::in_item_t t;
    t.action  = ACT_SEND;
    t.device  = dev;
    t.turn_on = on;
    return t;
  endfunction

  // length: mostly in range, sometimes zero or past the maximum; junk in upper bits
  function automatic logic [31:0] rand_len(int unsigned max_len, int unsigned field_max);
    int unsigned r;
    int unsigned n;
    r = $urandom_range(0, 9);
    if (r == 0) n = 0;
    else if (r == 1) n = $urandom_range(max_len + 1, field_max);
    else n = $urandom_range(1, max_len);
    return ($urandom & ~field_max) | n;
  endfunction

  // a few durations of zero to three ticks, mostly short multi-tick ones
  function automatic logic [31:0] rand_dur();
    int unsigned n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 24);
    return ($urandom & 32'hFFFF_0000) | n;
  endfunction

  task automatic send_item(ookpe_pkg::in_item_t it);
    int unsigned g;
    g = gap_len(tx_idle_pct);
    if (g > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.data  <= it;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    line_states_due.push_back(line_step(it));
    items_sent++;
  endtask

  // waits until nothing is in flight, then writes
  task automatic write_reg(logic [ookpe_pkg::CFG_ADDR_W-1:0] idx, logic [31:0] val);
    cmd_ch.valid <= 1'b0;
    while (line_states_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= {idx, val};
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (idx)
      ookpe_pkg::REG_TX_CODE:  enc_cfg.tx_code        = val;
      ookpe_pkg::REG_TX_LEN:   enc_cfg.tx_len         = val[5:0];
      ookpe_pkg::REG_CH_CODE:  enc_cfg.ch_code        = val[7:0];
      ookpe_pkg::REG_CH_LEN:   enc_cfg.ch_len         = val[3:0];
      ookpe_pkg::REG_HIGH:     enc_cfg.high_ticks     = val[ookpe_pkg::TICK_W-1:0];
      ookpe_pkg::REG_ONE_LOW:  enc_cfg.one_low_ticks  = val[ookpe_pkg::TICK_W-1:0];
      ookpe_pkg::REG_ZERO_LOW: enc_cfg.zero_low_ticks = val[ookpe_pkg::TICK_W-1:0];
      ookpe_pkg::REG_SYNC_LOW: enc_cfg.sync_low_ticks = val[ookpe_pkg::TICK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_timing(logic [31:0] hi, logic [31:0] one, logic [31:0] zero,
                              logic [31:0] sync);
    write_reg(ookpe_pkg::REG_HIGH, hi);
    write_reg(ookpe_pkg::REG_ONE_LOW, one);
    write_reg(ookpe_pkg::REG_ZERO_LOW, zero);
    write_reg(ookpe_pkg::REG_SYNC_LOW, sync);
  endtask

  task automatic test_idle_ticks();
    repeat (16) send_item(any_item(ACT_TICK));
  endtask

  // lengths past the maximum saturate; writes to unused indexes change nothing
  task automatic test_oversize_lengths();
    write_reg(ookpe_pkg::REG_TX_CODE, $urandom);
    write_reg(ookpe_pkg::REG_TX_LEN, 32'h3F);
    write_reg(ookpe_pkg::REG_CH_CODE, $urandom);
    write_reg(ookpe_pkg::REG_CH_LEN, 32'hF);
    write_reg(REG_SPARE, '1);
    write_reg(REG_TOP, $urandom);
    repeat (4) send_item(any_item(ACT_TICK));
  endtask

  // reset timing: runs past the end of the first high part, repeat commands refused
  task automatic test_default_frame();
    tx_idle_pct = 3;
    rx_idle_pct = 3;
    send_item(cmd_of(ookpe_pkg::DEV_GROUP, 1'b1));
    send_item(cmd_of(2'd0, 1'b0));
    repeat (DEFAULT_TICKS) send_item(any_item($urandom_range(0, 999) < 5));
  endtask

  // one-tick and zero durations written while the frame runs
  task automatic test_short_symbols();
    write_timing(1, 1, 1, 1);
    repeat (SHORT_TICKS) send_item(any_item(ACT_TICK));
    write_timing(0, 0, 0, 0);
    repeat (SHORT_TICKS) send_item(any_item($urandom_range(0, 99) < 10));
  endtask

  task automatic test_random_traffic();
    for (int unsigned rnd = 0; rnd < RANDOM_ROUNDS; rnd++) begin
      write_reg(ookpe_pkg::REG_TX_CODE, $urandom);
      write_reg(ookpe_pkg::REG_TX_LEN, rand_len(ookpe_pkg::TX_CODE_MAX, 63));
      write_reg(ookpe_pkg::REG_CH_CODE, $urandom);
      write_reg(ookpe_pkg::REG_CH_LEN, rand_len(ookpe_pkg::CH_CODE_MAX, 15));
      write_timing(rand_dur(), rand_dur(), rand_dur(), rand_dur());
      send_item(any_item(ACT_SEND));
      for (int unsigned i = 1; i < ROUND_ITEMS; i++) begin
        if (i % 60 == 1) begin
          tx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
          rx_idle_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        end
        // output side blocks for a long stretch while items keep coming
        if (rnd == 0 && i == 20) rx_hold_cycles = HOLD_CYCLES;
        send_item(any_item($urandom_range(0, 99) < 15));
      end
      tx_idle_pct = 3;
      rx_idle_pct = 3;
    end
  endtask

  task automatic check_bit(string name, logic exp_v, logic act_v);
    if (exp_v !== act_v) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $error("%s mismatch: expected %0b, actual %0b", name, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      results_seen++;
      if (line_states_due.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $error("result item with nothing pending: %b", rsp_ch.data);
      end else begin
        want = line_states_due.pop_front();
        check_bit("tx_level", want.tx_level, rsp_ch.data.tx_level);
        check_bit("busy_res", want.busy_res, rsp_ch.data.busy_res);
        check_bit("command_ignored", want.command_ignored, rsp_ch.data.command_ignored);
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               line_states_due.size());
      $display("ook_remote_packet_pulse_encoder verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned g;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_cycles > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        rx_hold_cycles = 0;
      end
      g = gap_len(rx_idle_pct);
      if (g > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (g) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  initial begin
    cmd_ch.valid   = 1'b0;
    cmd_ch.data    = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.data    = '0;
    tx_idle_pct    = 20;
    rx_idle_pct    = 20;
    rx_hold_cycles = 0;
    enc_cfg    = '{tx_code: '0, tx_len: '0, ch_code: '0, ch_len: '0,
                   high_ticks: ookpe_pkg::HIGH_RST,
                   one_low_ticks: ookpe_pkg::ONE_LOW_RST,
                   zero_low_ticks: ookpe_pkg::ZERO_LOW_RST,
                   sync_low_ticks: ookpe_pkg::SYNC_LOW_RST};
    enc_active = 1'b0;
    enc_part   = ookpe_pkg::PART_SYNC;
    enc_pos    = '0;
    enc_low    = 1'b0;
    enc_ticks  = '0;
    enc_rep    = '0;
    enc_cmd    = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_ticks();
    test_oversize_lengths();
    test_default_frame();
    test_short_symbols();
    test_random_traffic();

    cmd_ch.valid <= 1'b0;
    while (line_states_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("%0d items in, %0d results checked, %0d symbols sent, %0d busy commands refused",
             items_sent, results_seen, sym_cnt, ignored_cnt);
    $display("idle ticks, saturated lengths, reset/one-tick/zero/random timing; %0d rounds",
             RANDOM_ROUNDS);
    if (fail_cnt == 0) begin
      $display("ook_remote_packet_pulse_encoder verification clean");
    end else begin
      $display("ook_remote_packet_pulse_encoder verification failed");
    end
    $finish;
  end

endmodule
